// ===== rtl/core/dcd_pkg.sv =====
package dcd_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int YEAR_BITS      = 14;
  localparam int OFFSET_BITS    = 9;
  localparam int MONTH_BITS     = 4;
  localparam int DAY_BITS       = 5;
  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = 14;
  localparam int Y400_BITS      = 9;

  localparam logic [YEAR_BITS-1:0]   BASE_YEAR_RST    = 14'd2014;
  localparam logic [OFFSET_BITS-1:0] START_OFFSET_RST = 9'd91;
  localparam logic [YEAR_BITS-1:0]   YEAR_MAX         = 14'd16383;
  localparam logic [Y400_BITS-1:0]   LEAP_CYCLE       = 9'd400;
  localparam logic [Y400_BITS-1:0]   LEAP_CYCLE_LAST  = 9'd399;
  localparam logic [Y400_BITS-1:0]   LEAP_YEAR_DAYS   = 9'd366;
  localparam logic [Y400_BITS-1:0]   PLAIN_YEAR_DAYS  = 9'd365;
  localparam logic [MONTH_BITS-1:0]  MONTH_JAN        = 4'd1;
  localparam logic [MONTH_BITS-1:0]  MONTH_FEB        = 4'd2;
  localparam logic [MONTH_BITS-1:0]  MONTH_DEC        = 4'd12;
  localparam logic [DAY_BITS-1:0]    DAY_FIRST        = 5'd1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BASE_YEAR    = 1'b0,
    CFG_START_OFFSET = 1'b1
  } cfg_reg_e;

  // leap test on the year position inside the 400 year cycle
  function automatic logic is_leap(input logic [Y400_BITS-1:0] y400);
    logic div4;
    logic century;
    div4    = (y400[1:0] == 2'd0);
    century = (y400 == 9'd100) || (y400 == 9'd200) || (y400 == 9'd300);
    return div4 && !century;
  endfunction

  function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                    input logic leap);
    logic [DAY_BITS-1:0] len;
    case (m)
      4'd2:                       len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/dcd_sub.sv =====
module dcd_sub #(
  parameter int WIDTH = 17
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  output logic [WIDTH-1:0] diff_o,
  output logic             ge_o,
  output logic             gt_o
);

  logic [WIDTH:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[WIDTH-1:0];
  assign ge_o   = !full[WIDTH];
  assign gt_o   = !full[WIDTH] && (full[WIDTH-1:0] != '0);

endmodule

// ===== rtl/core/day_count_to_calendar_date.sv =====
// day count to gregorian date converter
// start_i with day_count_i hands in one item when busy_o is low; busy_o then
// stays high until the result comes out. the result is held on year_out_o,
// month_out_o and day_out_o, marked by done_o high for exactly one cycle; the
// receiver must take it then. busy_o falls in the cycle done_o is high, so a
// new item may be started while the result is shown.
// cfg_valid_i/cfg_ready_o write base_year (index 0) or start_offset (index 1);
// cfg_ready_o is always high and writes belong to idle periods.
// operation: one shared subtractor does all the subtractions, one step a cycle:
//   first base_year is placed in the 400 year cycle by repeated subtraction,
//   then whole years are taken off, then whole months, then done_o is
//   raised with the result; one item at a time.
// reset: registers return to base_year 2014 and start_offset 91, no item in
// flight and no result pending.
module day_count_to_calendar_date #(
  parameter int COUNT_BITS = dcd_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [COUNT_BITS-1:0]             day_count_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dcd_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [dcd_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output logic                              done_o,
  output logic [dcd_pkg::YEAR_BITS-1:0]     year_out_o,
  output logic [dcd_pkg::MONTH_BITS-1:0]    month_out_o,
  output logic [dcd_pkg::DAY_BITS-1:0]      day_out_o
);

  localparam int REST_BITS = ((COUNT_BITS > dcd_pkg::OFFSET_BITS) ? COUNT_BITS
                              : dcd_pkg::OFFSET_BITS) + 1;
  localparam int UNIT_BITS = (REST_BITS > dcd_pkg::YEAR_BITS) ? REST_BITS
                             : dcd_pkg::YEAR_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_YEAR,
    S_MONTH
  } state_e;

  state_e                          state_q;
  logic [dcd_pkg::YEAR_BITS-1:0]   base_year_q;
  logic [dcd_pkg::OFFSET_BITS-1:0] start_offset_q;
  logic [UNIT_BITS-1:0]            rest_q;
  logic [dcd_pkg::YEAR_BITS-1:0]   year_q;
  logic [dcd_pkg::YEAR_BITS-1:0]   y400_q;
  logic [dcd_pkg::MONTH_BITS-1:0]  month_q;
  logic                            zero_q;
  logic                            done_q;
  logic [dcd_pkg::YEAR_BITS-1:0]   year_out_q;
  logic [dcd_pkg::MONTH_BITS-1:0]  month_out_q;
  logic [dcd_pkg::DAY_BITS-1:0]    day_out_q;

  logic [UNIT_BITS-1:0] op_a;
  logic [UNIT_BITS-1:0] op_b;
  logic [UNIT_BITS-1:0] diff;
  logic                 ge;
  logic                 gt;
  logic                 leap;
  logic [UNIT_BITS-1:0] first_rest;

  assign leap       = dcd_pkg::is_leap(y400_q[dcd_pkg::Y400_BITS-1:0]);
  assign first_rest = UNIT_BITS'(day_count_i) + UNIT_BITS'(start_offset_q);

  always_comb begin
    case (state_q)
      S_MOD: begin
        op_a = UNIT_BITS'(y400_q);
        op_b = UNIT_BITS'(dcd_pkg::LEAP_CYCLE);
      end
      S_YEAR: begin
        op_a = rest_q;
        op_b = leap ? UNIT_BITS'(dcd_pkg::LEAP_YEAR_DAYS)
                    : UNIT_BITS'(dcd_pkg::PLAIN_YEAR_DAYS);
      end
      default: begin
        op_a = rest_q;
        op_b = UNIT_BITS'(dcd_pkg::month_len(month_q, leap));
      end
    endcase
  end

  dcd_sub #(
    .WIDTH(UNIT_BITS)
  ) u_sub (
    .a_i   (op_a),
    .b_i   (op_b),
    .diff_o(diff),
    .ge_o  (ge),
    .gt_o  (gt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_year_q    <= dcd_pkg::BASE_YEAR_RST;
      start_offset_q <= dcd_pkg::START_OFFSET_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dcd_pkg::CFG_BASE_YEAR:    base_year_q    <= cfg_data_i[dcd_pkg::YEAR_BITS-1:0];
        dcd_pkg::CFG_START_OFFSET: start_offset_q <= cfg_data_i[dcd_pkg::OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            rest_q  <= first_rest;
            zero_q  <= (first_rest == '0);
            year_q  <= base_year_q;
            y400_q  <= base_year_q;
            month_q <= dcd_pkg::MONTH_JAN;
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          // reduce the base year modulo 400 by repeated subtraction
          if (ge) begin
            y400_q <= diff[dcd_pkg::YEAR_BITS-1:0];
          end else begin
            state_q <= S_YEAR;
          end
        end
        S_YEAR: begin
          if (gt) begin
            rest_q <= diff;
            if (year_q != dcd_pkg::YEAR_MAX) begin
              year_q <= year_q + 1'b1;
            end
            // the cycle position keeps the leap rule right past saturation
            if (y400_q == dcd_pkg::YEAR_BITS'(dcd_pkg::LEAP_CYCLE_LAST)) begin
              y400_q <= '0;
            end else begin
              y400_q <= y400_q + 1'b1;
            end
          end else begin
            state_q <= S_MONTH;
          end
        end
        S_MONTH: begin
          if ((month_q != dcd_pkg::MONTH_DEC) && gt) begin
            rest_q  <= diff;
            month_q <= month_q + 1'b1;
          end else begin
            done_q      <= 1'b1;
            year_out_q  <= year_q;
            month_out_q <= month_q;
            day_out_q   <= zero_q ? dcd_pkg::DAY_FIRST : rest_q[dcd_pkg::DAY_BITS-1:0];
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign year_out_o  = year_out_q;
  assign month_out_o = month_out_q;
  assign day_out_o   = day_out_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy_o ##1 !done_o))
    else $error("result strobe longer than one cycle or while busy");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((month_out_o >= dcd_pkg::MONTH_JAN) && (month_out_o <= dcd_pkg::MONTH_DEC)
                && (day_out_o != '0)))
    else $error("month or day out of range");

  a_cycle_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_YEAR) || (state_q == S_MONTH))
      |-> (y400_q < dcd_pkg::YEAR_BITS'(dcd_pkg::LEAP_CYCLE)))
    else $error("year cycle position not reduced");

endmodule

// ===== tb/day_count_to_calendar_date_test.sv =====
module day_count_to_calendar_date_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CountBits = dcd_pkg::COUNT_BITS_DEF;
  localparam int RandomPhases = 10;
  localparam int ItemsPerPhase = 125;

  typedef struct packed {
    logic [dcd_pkg::YEAR_BITS-1:0]  year;
    logic [dcd_pkg::MONTH_BITS-1:0] month;
    logic [dcd_pkg::DAY_BITS-1:0]   day;
  } cal_date_t;

  class calendar_checker;
    logic [dcd_pkg::YEAR_BITS-1:0]   base_year;
    logic [dcd_pkg::OFFSET_BITS-1:0] start_offset;
    cal_date_t                       pending_dates[$];
    int unsigned                     failures;

    function new();
      base_year    = dcd_pkg::BASE_YEAR_RST;
      start_offset = dcd_pkg::START_OFFSET_RST;
      failures     = 0;
    endfunction

    function void write_reg(dcd_pkg::cfg_reg_e idx, logic [dcd_pkg::CFG_DATA_BITS-1:0] data);
      if (idx == dcd_pkg::CFG_BASE_YEAR) begin
        base_year = data;
      end else begin
        start_offset = data[dcd_pkg::OFFSET_BITS-1:0];
      end
    endfunction

    static function bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function int unsigned days_in_month(int unsigned m, bit leap);
      case (m)
        2:           return leap ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:     return 31;
      endcase
    endfunction

    function cal_date_t convert_day_count(logic [CountBits-1:0] cnt);
      int unsigned rest;
      int unsigned yr;
      int unsigned mon;
      bit          leap;
      cal_date_t   d;
      rest = int'(cnt) + int'(start_offset);
      yr   = int'(base_year);
      mon  = 1;
      // a zero total takes nothing off and lands on january 1
      if (rest == 0) rest = 1;
      while (rest > (leap_year(yr) ? 366 : 365)) begin
        rest -= leap_year(yr) ? 366 : 365;
        yr++;
      end
      leap = leap_year(yr);
      while (mon < 12 && rest > days_in_month(mon, leap)) begin
        rest -= days_in_month(mon, leap);
        mon++;
      end
      d.year  = (yr > dcd_pkg::YEAR_MAX) ? dcd_pkg::YEAR_MAX : yr[dcd_pkg::YEAR_BITS-1:0];
      d.month = mon[dcd_pkg::MONTH_BITS-1:0];
      d.day   = rest[dcd_pkg::DAY_BITS-1:0];
      return d;
    endfunction

    function void note_day_count(logic [CountBits-1:0] cnt);
      pending_dates.push_back(convert_day_count(cnt));
    endfunction

    function void check_date(logic [dcd_pkg::YEAR_BITS-1:0] y,
                             logic [dcd_pkg::MONTH_BITS-1:0] m,
                             logic [dcd_pkg::DAY_BITS-1:0] d);
      cal_date_t want;
      if (pending_dates.size() == 0) begin
        $error("result with no item pending: year %0d month %0d day %0d", y, m, d);
        failures++;
        return;
      end
      want = pending_dates.pop_front();
      if (y !== want.year) begin
        $error("year_out: expected %0d, got %0d", want.year, y);
        failures++;
      end
      if (m !== want.month) begin
        $error("month_out: expected %0d, got %0d", want.month, m);
        failures++;
      end
      if (d !== want.day) begin
        $error("day_out: expected %0d, got %0d", want.day, d);
        failures++;
      end
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start_i;
  logic                              busy_o;
  logic [CountBits-1:0]              day_count_i;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [dcd_pkg::CFG_IDX_BITS-1:0]  cfg_index_i;
  logic [dcd_pkg::CFG_DATA_BITS-1:0] cfg_data_i;
  logic                              done_o;
  logic [dcd_pkg::YEAR_BITS-1:0]     year_out_o;
  logic [dcd_pkg::MONTH_BITS-1:0]    month_out_o;
  logic [dcd_pkg::DAY_BITS-1:0]      day_out_o;

  calendar_checker dates = new();
  bit              no_gaps;

  day_count_to_calendar_date #(
    .COUNT_BITS(CountBits)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .day_count_i(day_count_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .year_out_o (year_out_o),
    .month_out_o(month_out_o),
    .day_out_o  (day_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) dates.check_date(year_out_o, month_out_o, day_out_o);
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(logic [CountBits-1:0] cnt);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i     <= 1'b1;
    day_count_i <= cnt;
    do @(posedge clk_i); while (busy_o);
    dates.note_day_count(cnt);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (dates.pending_dates.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(dcd_pkg::cfg_reg_e idx, logic [dcd_pkg::CFG_DATA_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    dates.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic set_calendar(logic [dcd_pkg::CFG_DATA_BITS-1:0] year,
                              logic [dcd_pkg::CFG_DATA_BITS-1:0] offset);
    write_reg(dcd_pkg::CFG_BASE_YEAR, year);
    write_reg(dcd_pkg::CFG_START_OFFSET, offset);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CountBits-1:0] random_count();
    // a quarter short counts so the first years and months get hit often
    if ($urandom_range(0, 3) == 0) return CountBits'($urandom_range(0, 1500));
    return CountBits'($urandom_range(0, (1 << CountBits) - 1));
  endfunction

  initial begin
    logic [dcd_pkg::CFG_DATA_BITS-1:0] year;
    int                                pick;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    day_count_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = dcd_pkg::CFG_BASE_YEAR;
    cfg_data_i  = '0;
    no_gaps     = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset calendar: day one is the start day, then around the end of that year
    send_item(1);
    send_item(2);
    send_item(274);
    send_item(275);
    send_item('1);
    wait_idle();

    // year zero is leap, zero total
    set_calendar(0, 0);
    send_item(0);
    send_item(59);
    send_item(60);
    send_item(366);
    send_item(367);
    wait_idle();

    // year saturation with the largest offset
    set_calendar(dcd_pkg::YEAR_MAX, 511);
    send_item(1);
    send_item('1);
    wait_idle();

    // century that is not leap, then one that is
    set_calendar(1900, 0);
    send_item(59);
    send_item(60);
    send_item(365);
    send_item(366);
    wait_idle();
    set_calendar(2000, 0);
    send_item(60);
    send_item(366);
    send_item(367);
    wait_idle();

    // offset bits above the register width are dropped
    set_calendar(1, 14'h3E00 | 14'd365);
    send_item(1);
    send_item('1);
    wait_idle();
    set_calendar(9999, 0);
    send_item(1);
    send_item(16'h8000);
    wait_idle();

    for (int p = 0; p < RandomPhases; p++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) year = 0;
      else if (pick == 1) year = dcd_pkg::YEAR_MAX;
      else year = dcd_pkg::CFG_DATA_BITS'($urandom_range(1, 9999));
      set_calendar(year, dcd_pkg::CFG_DATA_BITS'(
                           $urandom_range(0, (1 << dcd_pkg::CFG_DATA_BITS) - 1)));
      no_gaps = (p % 3 == 1);
      repeat (ItemsPerPhase) send_item(random_count());
      wait_idle();
    end

    repeat (300) @(posedge clk_i);
    if (dates.pending_dates.size() != 0) begin
      $error("%0d results never arrived", dates.pending_dates.size());
    end
    if (dates.failures == 0 && dates.pending_dates.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
